// ===== hdl/dma_otc_pkg.sv =====
// Shared types, constants and helpers for the DMA register block with
// ordering-table clear. No dependencies.
package dma_otc_pkg;

  localparam int unsigned NumChannels = 7;
  localparam int unsigned ChanW       = 3;

  typedef enum logic [1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpTick  = 2'd2,
    OpIdle  = 2'd3
  } op_e;

  localparam logic [ChanW-1:0] ChGpu = 3'd2;
  localparam logic [ChanW-1:0] ChOtc = 3'd6;

  localparam logic [3:0] SlotBase  = 4'h0;
  localparam logic [3:0] SlotBlock = 4'h4;
  localparam logic [3:0] SlotCtrl  = 4'h8;

  localparam logic [6:0] OffPriority  = 7'h70;
  localparam logic [6:0] OffInterrupt = 7'h74;

  localparam logic [31:0] CtlStart   = 32'h0100_0000;
  localparam logic [31:0] CtlTrigger = 32'h1000_0000;
  localparam logic [31:0] CtlOtcKeep = 32'h5100_0000;
  localparam logic [31:0] CtlBackstep = 32'h0000_0002;

  localparam logic [31:0] IwWritable = 32'h00ff_803f;
  localparam logic [31:0] IwFlags    = 32'h7f00_0000;

  localparam logic [31:0] PriorityReset = 32'h0765_4321;
  localparam logic [23:0] LinkMask      = 24'h1f_fffc;
  localparam logic [23:0] LinkEnd       = 24'hff_ffff;
  localparam logic [23:0] BaseMask      = 24'hff_fffc;
  localparam logic [16:0] FullCount     = 17'h1_0000;

  typedef struct packed {
    logic [23:0] base;
    logic [31:0] block;
    logic [31:0] ctrl;
  } chan_row_t;

  // Recompute the master bit (31) of the interrupt word.
  function automatic logic [31:0] iw_eval(logic [31:0] iw);
    logic status;
    logic on;
    status = |(iw[30:24] & iw[22:16]);
    on     = iw[15] | (iw[23] & status);
    return {on, iw[30:0]};
  endfunction

endpackage

// ===== hdl/dma_registers_otc_clear_top.sv =====
// DMA register block top level: bus reads/writes, ticks of the OT clear engine.
// Depends on dma_otc_pkg.
//
// One item is taken per clock cycle while the output is not stalled; each
// result is registered as its item leaves the second stage. The per-channel
// base, block and control words sit in a 7-row memory (one row per channel)
// with a registered read: an item reads its row on acceptance and the second
// stage modifies and writes it back, with the row just written forwarded to an
// item that read it in the same cycle. Priority, interrupt and table-pointer
// state live in flops; unwritten rows read as zero, needing no clear at reset.
module dma_registers_otc_clear_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [6:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        mem_write_valid_o,
  output logic [20:0] mem_address_o,
  output logic [23:0] mem_data_o,
  output logic        irq_pulse_o,
  output logic        busy_res_o,
  output logic        error_o
);
  import dma_otc_pkg::*;

  chan_row_t        mem_q [NumChannels];
  logic [NumChannels-1:0] row_vld_q;

  logic             s1_valid_q;
  logic [1:0]       s1_op_q;
  logic [6:0]       s1_off_q;
  logic [31:0]      s1_wdata_q;
  chan_row_t        rd_row_q;
  logic             rd_vld_q;
  logic             fwd_hit_q;
  chan_row_t        fwd_row_q;

  logic [31:0]      prio_q, prio_d;
  logic [31:0]      iw_q, iw_d;
  logic [23:0]      ptr_q, ptr_d;
  logic [16:0]      left_q, left_d;
  logic             run_q, run_d;

  logic             accept;
  logic             s1_adv;
  logic [ChanW-1:0] rd_ch;
  logic [ChanW-1:0] in_ch;
  logic             fwd_hit_d;

  chan_row_t        cur_row;
  chan_row_t        wr_row;
  logic             we;
  logic [ChanW-1:0] wr_ch;
  logic [ChanW-1:0] s1_ch;
  logic [3:0]       s1_slot;
  logic [31:0]      rd_d;
  logic             wv_d;
  logic [23:0]      addr_d;
  logic [23:0]      data_d;
  logic             irq_d;
  logic             err_d;
  logic [31:0]      cv;
  logic [31:0]      iw_tmp;
  logic             trig;
  logic             act;
  logic             en;
  logic [16:0]      left_dec;

  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_ch = reg_offset_i[6:4];
  always_comb begin
    if (operation_i == OpTick) begin
      rd_ch = ChOtc;
    end else if (in_ch == ChanW'(NumChannels)) begin
      rd_ch = '0;
    end else begin
      rd_ch = in_ch;
    end
  end
  assign fwd_hit_d = s1_adv && we && (wr_ch == rd_ch);

  always_ff @(posedge clk_i) begin
    if (we && s1_adv) begin
      mem_q[wr_ch] <= wr_row;
    end
    if (accept) begin
      rd_row_q <= mem_q[rd_ch];
    end
  end

  assign cur_row = fwd_hit_q ? fwd_row_q : (rd_vld_q ? rd_row_q : '0);
  assign s1_ch   = s1_off_q[6:4];
  assign s1_slot = s1_off_q[3:0];
  assign left_dec = left_q - 17'd1;

  always_comb begin
    rd_d   = '0;
    wv_d   = 1'b0;
    addr_d = '0;
    data_d = '0;
    irq_d  = 1'b0;
    err_d  = 1'b0;
    we     = 1'b0;
    wr_ch  = (s1_op_q == OpTick) ? ChOtc : s1_ch;
    wr_row = cur_row;
    prio_d = prio_q;
    iw_d   = iw_q;
    ptr_d  = ptr_q;
    left_d = left_q;
    run_d  = run_q;
    cv     = '0;
    iw_tmp = iw_q;
    trig   = 1'b0;
    act    = 1'b0;
    en     = 1'b0;
    if ((s1_op_q == OpRead || s1_op_q == OpWrite) && run_q) begin
      err_d = 1'b1;
    end else if (s1_op_q == OpRead) begin
      if (s1_off_q < OffPriority) begin
        unique case (s1_slot)
          SlotBase:  rd_d = {8'd0, cur_row.base};
          SlotBlock: rd_d = cur_row.block;
          SlotCtrl:  rd_d = cur_row.ctrl;
          default:   err_d = 1'b1;
        endcase
      end else if (s1_off_q == OffPriority) begin
        rd_d = prio_q;
      end else if (s1_off_q == OffInterrupt) begin
        rd_d = iw_q;
      end else begin
        err_d = 1'b1;
      end
    end else if (s1_op_q == OpWrite) begin
      if (s1_off_q < OffPriority) begin
        unique case (s1_slot)
          SlotBase: begin
            we          = 1'b1;
            wr_row.base = s1_wdata_q[23:0];
          end
          SlotBlock: begin
            we           = 1'b1;
            wr_row.block = s1_wdata_q;
          end
          SlotCtrl: begin
            cv   = (s1_ch == ChOtc) ? ((s1_wdata_q & CtlOtcKeep) | CtlBackstep)
                                    : s1_wdata_q;
            trig = (cv[10:9] == 2'd0) ? cv[28] : 1'b1;
            act  = cv[24] && trig;
            en   = prio_q[{s1_ch, 2'b11}];
            if (!(act && en)) begin
              we          = 1'b1;
              wr_row.ctrl = cv;
            end else if (s1_ch != ChOtc && s1_ch != ChGpu) begin
              err_d = 1'b1;
            end else if (s1_ch == ChGpu) begin
              we          = 1'b1;
              wr_row.ctrl = cv & ~CtlTrigger & ~CtlStart;
              if (iw_q[16 + ChGpu]) begin
                iw_tmp             = iw_q;
                iw_tmp[24 + ChGpu] = 1'b1;
                iw_d               = iw_eval(iw_tmp);
                irq_d              = iw_d[31] && !iw_q[31];
              end
            end else begin
              we          = 1'b1;
              wr_row.ctrl = cv & ~CtlTrigger;
              left_d      = (cur_row.block[15:0] == 16'd0) ? FullCount
                                                          : {1'b0, cur_row.block[15:0]};
              ptr_d       = cur_row.base & BaseMask;
              run_d       = 1'b1;
            end
          end
          default: err_d = 1'b1;
        endcase
      end else if (s1_off_q == OffPriority) begin
        prio_d = s1_wdata_q;
      end else if (s1_off_q == OffInterrupt) begin
        iw_tmp = (iw_q & ~IwWritable & ~(s1_wdata_q & IwFlags)) | (s1_wdata_q & IwWritable);
        iw_d   = iw_eval(iw_tmp);
        irq_d  = iw_d[31] && !iw_q[31];
      end else begin
        err_d = 1'b1;
      end
    end else if (s1_op_q == OpTick && run_q) begin
      data_d = (left_q == 17'd1) ? LinkEnd : ((ptr_q - 24'd4) & LinkMask);
      wv_d   = 1'b1;
      addr_d = ptr_q & LinkMask;
      ptr_d  = data_d;
      left_d = left_dec;
      if (left_dec == 17'd0) begin
        run_d       = 1'b0;
        we          = 1'b1;
        wr_row.ctrl = cur_row.ctrl & ~CtlStart;
        if (iw_q[16 + ChOtc]) begin
          iw_tmp             = iw_q;
          iw_tmp[24 + ChOtc] = 1'b1;
          iw_d               = iw_eval(iw_tmp);
          irq_d              = iw_d[31] && !iw_q[31];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      fwd_hit_q   <= 1'b0;
      prio_q      <= PriorityReset;
      iw_q        <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      run_q       <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        rd_vld_q   <= row_vld_q[rd_ch];
        fwd_hit_q  <= fwd_hit_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_o <= 1'b1;
        prio_q      <= prio_d;
        iw_q        <= iw_d;
        ptr_q       <= ptr_d;
        left_q      <= left_d;
        run_q       <= run_d;
        if (we) begin
          row_vld_q[wr_ch] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= operation_i;
      s1_off_q   <= reg_offset_i;
      s1_wdata_q <= write_data_i;
      fwd_row_q  <= wr_row;
    end
    if (s1_adv) begin
      read_data_o       <= rd_d;
      mem_write_valid_o <= wv_d;
      mem_address_o     <= addr_d[20:0];
      mem_data_o        <= data_d;
      irq_pulse_o       <= irq_d;
      busy_res_o        <= run_d;
      error_o           <= err_d;
    end
  end

endmodule

// ===== hdl/dma_otc_checker.sv =====
// Port-level checker for the DMA register block and its bind statement.
// Depends on dma_registers_otc_clear_top.
module dma_otc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        mem_write_valid_o,
  input logic [20:0] mem_address_o,
  input logic [23:0] mem_data_o,
  input logic        busy_res_o,
  input logic        error_o
);

  a_no_err_on_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_write_valid_o |-> !error_o && read_data_o == 32'd0)
    else $error("table word reported together with error or read data");

  a_word_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_write_valid_o |-> mem_address_o[1:0] == 2'b00)
    else $error("table word address not word aligned");

  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_write_valid_o |->
      ((mem_data_o == 24'hff_ffff) != busy_res_o))
    else $error("terminator and busy flag disagree");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mem_data_o) &&
      $stable(read_data_o))
    else $error("stalled result changed");

endmodule

bind dma_registers_otc_clear_top dma_otc_checker u_dma_otc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .read_data_o       (read_data_o),
  .mem_write_valid_o (mem_write_valid_o),
  .mem_address_o     (mem_address_o),
  .mem_data_o        (mem_data_o),
  .busy_res_o        (busy_res_o),
  .error_o           (error_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for dma_registers_otc_clear_top: directed register and table cases,
// then random bus, interrupt and table traffic checked against an in-bench predictor.
// Depends on dma_otc_pkg and the RTL of the block.
module tb;
  import dma_otc_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int RandomItems = 900;

  localparam logic [6:0] OffDma0Ctrl = {3'd0, SlotCtrl};
  localparam logic [6:0] OffGpuCtrl  = {ChGpu, SlotCtrl};
  localparam logic [6:0] OffOtcBase  = {ChOtc, SlotBase};
  localparam logic [6:0] OffOtcBlock = {ChOtc, SlotBlock};
  localparam logic [6:0] OffOtcCtrl  = {ChOtc, SlotCtrl};
  localparam logic [6:0] OffHole     = 7'h0c;
  localparam logic [6:0] OffOdd      = 7'h71;
  localparam logic [6:0] OffPastEnd  = 7'h7c;

  typedef struct packed {
    logic [31:0] rd;
    logic        wv;
    logic [20:0] addr;
    logic [23:0] data;
    logic        irq;
    logic        busy;
    logic        err;
  } dma_res_t;

  typedef struct packed {
    op_e         op;
    logic [6:0]  off;
    logic [31:0] wd;
    logic        chk;
    logic [31:0] rd;
    logic        irq;
    logic        err;
    logic        busy;
  } row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OpIdle;
  logic [6:0]  reg_offset_i = '0;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic        mem_write_valid_o;
  logic [20:0] mem_address_o;
  logic [23:0] mem_data_o;
  logic        irq_pulse_o;
  logic        busy_res_o;
  logic        error_o;

  // predicted register and engine state
  logic [23:0] m_base [NumChannels];
  logic [31:0] m_block [NumChannels];
  logic [31:0] m_ctrl [NumChannels];
  logic [31:0] m_prio;
  logic [31:0] m_iw;
  logic [23:0] m_ptr;
  logic [16:0] m_left;
  logic        m_run;

  dma_res_t due_q [$];
  int fails = 0;
  int n_items = 0;
  int n_useful = 0;
  int n_results = 0;
  int n_words = 0;
  int n_irq = 0;
  int n_err = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  row_t dir_rows [25] = '{
    '{OpRead,  OffPriority,  32'h0,         1'b1, PriorityReset, 1'b0, 1'b0, 1'b0},
    '{OpRead,  OffInterrupt, 32'h0,         1'b1, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpRead,  OffOtcCtrl,   32'h0,         1'b1, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpRead,  OffHole,      32'h0,         1'b1, 32'h0,         1'b0, 1'b1, 1'b0},
    '{OpWrite, OffPastEnd,   32'hffff_ffff, 1'b1, 32'h0,         1'b0, 1'b1, 1'b0},
    '{OpRead,  OffOdd,       32'h0,         1'b1, 32'h0,         1'b0, 1'b1, 1'b0},
    '{OpIdle,  OffPastEnd,   32'hffff_ffff, 1'b1, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpTick,  OffOdd,       32'hffff_ffff, 1'b1, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffPriority,  32'hffff_ffff, 1'b1, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffInterrupt, 32'h0000_8000, 1'b1, 32'h0,         1'b1, 1'b0, 1'b0},
    '{OpRead,  OffInterrupt, 32'h0,         1'b1, 32'h8000_8000, 1'b0, 1'b0, 1'b0},
    '{OpWrite, OffInterrupt, 32'h00ff_0000, 1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffDma0Ctrl,  32'h0100_0200, 1'b1, 32'h0,         1'b0, 1'b1, 1'b0},
    '{OpWrite, OffGpuCtrl,   32'h1100_0000, 1'b1, 32'h0,         1'b1, 1'b0, 1'b0},
    '{OpRead,  OffGpuCtrl,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffInterrupt, 32'h7fff_0000, 1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffOtcBase,   32'hfffe_0004, 1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffOtcBlock,  32'hffff_0003, 1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffOtcCtrl,   32'h5100_0000, 1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpRead,  OffPriority,  32'h0,         1'b1, 32'h0,         1'b0, 1'b1, 1'b1},
    '{OpTick,  OffHole,      32'h0,         1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpTick,  OffHole,      32'h0,         1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpTick,  OffHole,      32'h0,         1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpRead,  OffOtcCtrl,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0, 1'b0},
    '{OpWrite, OffPriority,  32'h0,         1'b0, 32'h0,         1'b0, 1'b0, 1'b0}
  };

  dma_registers_otc_clear_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .reg_offset_i      (reg_offset_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .mem_write_valid_o (mem_write_valid_o),
    .mem_address_o     (mem_address_o),
    .mem_data_o        (mem_data_o),
    .irq_pulse_o       (irq_pulse_o),
    .busy_res_o        (busy_res_o),
    .error_o           (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(11, 40));
  endfunction

  // master bit: force, or enable with any flag whose mask is set; returns the rise
  function automatic logic master_rise();
    logic was;
    logic on;
    was = m_iw[31];
    on = m_iw[15] | (m_iw[23] & (|(m_iw[30:24] & m_iw[22:16])));
    m_iw[31] = on;
    return on & ~was;
  endfunction

  function automatic logic close_xfer(input int ch);
    m_ctrl[ch] = m_ctrl[ch] & ~CtlStart;
    if (m_iw[16 + ch]) begin
      m_iw[24 + ch] = 1'b1;
      return master_rise();
    end
    return 1'b0;
  endfunction

  function automatic dma_res_t dma_step(input op_e op, input logic [6:0] off,
                                        input logic [31:0] wd);
    dma_res_t r;
    int ch;
    logic [3:0] slot;
    logic [31:0] v;
    logic trig;
    logic go;
    r = '0;
    ch = int'(off[6:4]);
    slot = off[3:0];
    if ((op == OpRead || op == OpWrite) && m_run) begin
      r.err = 1'b1;
    end else if (op == OpRead) begin
      if (off < OffPriority) begin
        case (slot)
          SlotBase:  r.rd = {8'h0, m_base[ch]};
          SlotBlock: r.rd = m_block[ch];
          SlotCtrl:  r.rd = m_ctrl[ch];
          default:   r.err = 1'b1;
        endcase
      end else if (off == OffPriority) begin
        r.rd = m_prio;
      end else if (off == OffInterrupt) begin
        r.rd = m_iw;
      end else begin
        r.err = 1'b1;
      end
    end else if (op == OpWrite) begin
      if (off < OffPriority) begin
        case (slot)
          SlotBase:  m_base[ch] = wd[23:0];
          SlotBlock: m_block[ch] = wd;
          SlotCtrl: begin
            v = (ch == ChOtc) ? ((wd & CtlOtcKeep) | CtlBackstep) : wd;
            trig = (v[10:9] == 2'd0) ? ((v & CtlTrigger) != 0) : 1'b1;
            go = ((v & CtlStart) != 0) && trig && m_prio[ch * 4 + 3];
            if (!go) begin
              m_ctrl[ch] = v;
            end else if (ch != ChGpu && ch != ChOtc) begin
              r.err = 1'b1;
            end else begin
              m_ctrl[ch] = v & ~CtlTrigger;
              if (ch == ChGpu) begin
                r.irq = close_xfer(ch);
              end else begin
                m_left = (m_block[ch][15:0] == 16'd0) ? FullCount : {1'b0, m_block[ch][15:0]};
                m_ptr = m_base[ch] & BaseMask;
                m_run = 1'b1;
              end
            end
          end
          default: r.err = 1'b1;
        endcase
      end else if (off == OffPriority) begin
        m_prio = wd;
      end else if (off == OffInterrupt) begin
        m_iw = (m_iw & ~IwWritable & ~(wd & IwFlags)) | (wd & IwWritable);
        r.irq = master_rise();
      end else begin
        r.err = 1'b1;
      end
    end else if (op == OpTick && m_run) begin
      r.wv = 1'b1;
      r.addr = m_ptr[20:0] & LinkMask[20:0];
      r.data = (m_left == 17'd1) ? LinkEnd : ((m_ptr - 24'd4) & LinkMask);
      m_ptr = r.data;
      m_left = m_left - 17'd1;
      if (m_left == 17'd0) begin
        m_run = 1'b0;
        r.irq = close_xfer(ChOtc);
      end
    end
    r.busy = m_run;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fails++;
    if (fails <= 50)
      $display("mismatch: %s got %h want %h at result %0d", what, got, want, n_results);
  endtask

  task automatic check_out();
    dma_res_t w;
    if (due_q.size() == 0) begin
      report("result with nothing pending, read_data", read_data_o, 32'h0);
    end else begin
      w = due_q.pop_front();
      n_results++;
      n_words += w.wv;
      n_irq += w.irq;
      n_err += w.err;
      if (read_data_o !== w.rd) report("read_data", read_data_o, w.rd);
      if (mem_write_valid_o !== w.wv)
        report("mem_write_valid", 32'(mem_write_valid_o), 32'(w.wv));
      if (mem_address_o !== w.addr)
        report("mem_address", 32'(mem_address_o), 32'(w.addr));
      if (mem_data_o !== w.data) report("mem_data", 32'(mem_data_o), 32'(w.data));
      if (irq_pulse_o !== w.irq) report("irq_pulse", 32'(irq_pulse_o), 32'(w.irq));
      if (busy_res_o !== w.busy) report("busy_res", 32'(busy_res_o), 32'(w.busy));
      if (error_o !== w.err) report("error", 32'(error_o), 32'(w.err));
    end
  endtask

  // result side: check each accepted item, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_out();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = gap_len();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_q.size());
      $display("dma_registers_otc_clear_top regression: fail");
      $finish;
    end
  end

  task automatic send(input op_e op, input logic [6:0] off, input logic [31:0] wd,
                      input logic typed, input dma_res_t want);
    dma_res_t r;
    int g;
    operation_i <= op;
    reg_offset_i <= off;
    write_data_i <= wd;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = dma_step(op, off, wd);
    due_q.push_back(typed ? want : r);
    n_items++;
    if (!r.err && op != OpIdle && (op != OpTick || r.wv)) n_useful++;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
  endtask

  initial begin
    dma_res_t typed_res;
    op_e op;
    logic [6:0] off;
    logic [31:0] wd;
    int sel;
    int k;
    int start_items;
    for (int c = 0; c < NumChannels; c++) begin
      m_base[c] = '0;
      m_block[c] = '0;
      m_ctrl[c] = '0;
    end
    m_prio = PriorityReset;
    m_iw = '0;
    m_ptr = '0;
    m_left = '0;
    m_run = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed_res = '0;
      typed_res.rd = dir_rows[i].rd;
      typed_res.irq = dir_rows[i].irq;
      typed_res.err = dir_rows[i].err;
      typed_res.busy = dir_rows[i].busy;
      send(dir_rows[i].op, dir_rows[i].off, dir_rows[i].wd, dir_rows[i].chk, typed_res);
    end
    drain();

    k = 0;
    start_items = n_items;
    while (n_items - start_items < RandomItems) begin
      if (k % 200 == 199) drain();
      calm = (k >= 500 && k < 600);
      sel = int'($urandom_range(0, 99));
      wd = $urandom;
      off = 7'($urandom_range(0, 127));
      op = OpWrite;
      if (m_run) begin
        if (sel < 85) op = OpTick;
        else op = op_e'(2'($urandom_range(0, 1)));
      end else if (sel < 20) begin
        op = OpRead;
        if ($urandom_range(0, 1) == 1)
          off = 7'($urandom_range(0, 6) * 16 + $urandom_range(0, 2) * 4);
      end else if (sel < 40) begin
        off = 7'($urandom_range(0, 6) * 16 + $urandom_range(0, 1) * 4);
      end else if (sel < 50) begin
        off = OffPriority;
        if ($urandom_range(0, 3) != 0) wd = wd | 32'h0800_0800;
      end else if (sel < 60) begin
        off = OffInterrupt;
        if ($urandom_range(0, 1) == 1) wd = wd & ~32'h0000_8000;
      end else if (sel < 72) begin
        off = 7'($urandom_range(0, 6) * 16) | SlotCtrl;
        if ($urandom_range(0, 1) == 1) wd = wd | CtlStart | CtlTrigger;
      end else if (sel < 87) begin
        off = OffOtcCtrl;
        wd = wd | CtlStart | CtlTrigger;
      end else if (sel < 92) begin
        op = OpTick;
      end else if (sel < 96) begin
        op = OpIdle;
      end
      // keep random tables short
      if (op == OpWrite && off == OffOtcBlock) wd[15:0] = 16'($urandom_range(1, 16));
      send(op, off, wd, 1'b0, '0);
      k++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (due_q.size() != 0) report("results still outstanding", 32'(due_q.size()), 32'h0);
    $display("covered %0d items (%0d effective): %0d results, %0d table words, %0d irq pulses",
             n_items, n_useful, n_results, n_words, n_irq);
    $display("%0d rejected items; GPU and table starts, stalls on both sides", n_err);
    if (fails == 0) begin
      $display("dma_registers_otc_clear_top regression: pass");
    end else begin
      $display("dma_registers_otc_clear_top regression: fail");
    end
    $finish;
  end

endmodule
